@@ hdl/smbx_pkg.sv @@
// ----------------------------------------------------------------------------
// SMBIOS string extractor package
// Shared types and constants for the structure table string extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package smbx_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaskW = 5;
  localparam int unsigned NumW  = 9;
  localparam int unsigned SeenW = 3;

  localparam logic [ByteW-1:0] TypeBios  = 8'd0;
  localparam logic [ByteW-1:0] TypeSys   = 8'd1;
  localparam logic [ByteW-1:0] TypeBoard = 8'd2;
  localparam logic [ByteW-1:0] TypeEnd   = 8'd127;
  localparam logic [ByteW-1:0] MinLength = 8'd4;
  localparam logic [ByteW-1:0] OffIdx4   = 8'h04;
  localparam logic [ByteW-1:0] OffIdx5   = 8'h05;
  localparam logic [ByteW-1:0] OffIdx6   = 8'h06;
  localparam logic [NumW-1:0]  NumSat    = 9'd256;
  localparam logic [SeenW-1:0] SeenAll   = 3'b111;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_SET_START = 6'b000010,
    PH_IN_STRING = 6'b000100,
    PH_BETWEEN   = 6'b001000,
    PH_SKIP      = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] char_byte;
    logic             char_valid;
    logic [MaskW-1:0] field_mask;
    logic             string_end;
    logic             table_done;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/smbx_chan_if.sv @@
// ----------------------------------------------------------------------------
// SMBIOS string extractor channels
// Valid/ready channel interfaces for table bytes and extracted characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface smbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       table_end;

  modport source (output valid, output data_byte, output table_end, input ready);
  modport sink (input valid, input data_byte, input table_end, output ready);
endinterface

interface smbx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       char_valid;
  logic [4:0] field_mask;
  logic       string_end;
  logic       table_done;

  modport source (
    output valid, output char_byte, output char_valid, output field_mask,
    output string_end, output table_done, input ready
  );
  modport sink (
    input valid, input char_byte, input char_valid, input field_mask,
    input string_end, input table_done, output ready
  );
endinterface

`default_nettype wire

@@ hdl/smbx_parser.sv @@
// ----------------------------------------------------------------------------
// SMBIOS string extractor parser
// Per-byte record parser: tracks the header, counts strings and tags bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module smbx_parser
  import smbx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic             table_end,
  output logic                  res_valid,
  output result_t               res
);

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] offset_r, offset_nxt;
  logic [ByteW-1:0] type_r, type_nxt;
  logic [ByteW-1:0] length_r, length_nxt;
  logic [ByteW-1:0] idx4_r, idx4_nxt;
  logic [ByteW-1:0] idx5_r, idx5_nxt;
  logic [ByteW-1:0] idx6_r, idx6_nxt;
  logic [NumW-1:0]  num_r, num_nxt;
  logic [SeenW-1:0] seen_r, seen_nxt;

  logic [NumW-1:0]  num_inc;
  logic [SeenW-1:0] seen_fin;
  logic             fin_all;
  logic [MaskW-1:0] mask;
  logic             emit, done, cvalid, send, open_str;

  function automatic logic [MaskW-1:0] field_sel(
    input logic [NumW-1:0]  n,
    input logic [ByteW-1:0] rtype,
    input logic [ByteW-1:0] i4,
    input logic [ByteW-1:0] i5,
    input logic [ByteW-1:0] i6,
    input logic [SeenW-1:0] seen
  );
    logic [MaskW-1:0] m;
    m = '0;
    if (n != '0 && !n[NumW-1]) begin
      if (rtype == TypeBios && !seen[0]) begin
        m[0] = (i4 == n[ByteW-1:0]);
      end else if (rtype == TypeSys && !seen[1]) begin
        m[1] = (i4 == n[ByteW-1:0]);
        m[2] = (i5 == n[ByteW-1:0]);
        m[3] = (i6 == n[ByteW-1:0]);
      end else if (rtype == TypeBoard && !seen[2]) begin
        m[4] = (i4 == n[ByteW-1:0]);
      end
    end
    return m;
  endfunction

  always_comb begin
    num_inc  = (num_r == NumSat) ? NumSat : num_r + NumW'(1);
    seen_fin = seen_r;
    unique case (type_r)
      TypeBios:  seen_fin = seen_r | 3'b001;
      TypeSys:   seen_fin = seen_r | 3'b010;
      TypeBoard: seen_fin = seen_r | 3'b100;
      default:   seen_fin = seen_r;
    endcase
    fin_all = (seen_fin == SeenAll);
  end

  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    idx4_nxt   = idx4_r;
    idx5_nxt   = idx5_r;
    idx6_nxt   = idx6_r;
    num_nxt    = num_r;
    seen_nxt   = seen_r;
    mask       = '0;
    emit       = 1'b0;
    done       = 1'b0;
    cvalid     = 1'b0;
    send       = 1'b0;
    open_str   = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (offset_r == 8'd0) begin
          type_nxt   = data_byte;
          idx4_nxt   = '0;
          idx5_nxt   = '0;
          idx6_nxt   = '0;
          offset_nxt = 8'd1;
        end else if (offset_r == 8'd1) begin
          length_nxt = data_byte;
          if (type_r == TypeEnd || data_byte < MinLength) begin
            phase_nxt = PH_DONE;
            done      = 1'b1;
          end else begin
            offset_nxt = 8'd2;
          end
        end else begin
          if (offset_r == OffIdx4) idx4_nxt = data_byte;
          if (offset_r == OffIdx5) idx5_nxt = data_byte;
          if (offset_r == OffIdx6) idx6_nxt = data_byte;
          if ({1'b0, offset_r} + 9'd1 == {1'b0, length_r}) begin
            phase_nxt = PH_SET_START;
            num_nxt   = '0;
          end else begin
            offset_nxt = offset_r + 8'd1;
          end
        end
      end
      PH_SET_START, PH_BETWEEN: begin
        if (data_byte != '0) begin
          num_nxt   = num_inc;
          phase_nxt = PH_IN_STRING;
          mask      = field_sel(num_inc, type_r, idx4_r, idx5_r, idx6_r, seen_r);
          cvalid    = |mask;
          emit      = |mask;
          open_str  = 1'b1;
        end else if (phase_r == PH_SET_START) begin
          phase_nxt = PH_SKIP;
        end else begin
          seen_nxt   = seen_fin;
          offset_nxt = '0;
          phase_nxt  = fin_all ? PH_DONE : PH_HEADER;
          done       = fin_all;
        end
      end
      PH_IN_STRING: begin
        mask = field_sel(num_r, type_r, idx4_r, idx5_r, idx6_r, seen_r);
        if (data_byte != '0) begin
          cvalid   = |mask;
          emit     = |mask;
          open_str = 1'b1;
        end else begin
          send      = |mask;
          emit      = |mask;
          phase_nxt = PH_BETWEEN;
        end
      end
      PH_SKIP: begin
        seen_nxt   = seen_fin;
        offset_nxt = '0;
        phase_nxt  = fin_all ? PH_DONE : PH_HEADER;
        done       = fin_all;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (table_end) begin
      if (open_str && (mask != '0)) send = 1'b1;
      if (phase_r != PH_DONE) done = 1'b1;
      phase_nxt  = PH_HEADER;
      offset_nxt = '0;
      type_nxt   = '0;
      length_nxt = '0;
      idx4_nxt   = '0;
      idx5_nxt   = '0;
      idx6_nxt   = '0;
      num_nxt    = '0;
      seen_nxt   = '0;
    end
    if (done) emit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      offset_r <= '0;
      type_r   <= '0;
      length_r <= '0;
      idx4_r   <= '0;
      idx5_r   <= '0;
      idx6_r   <= '0;
      num_r    <= '0;
      seen_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      type_r   <= type_nxt;
      length_r <= length_nxt;
      idx4_r   <= idx4_nxt;
      idx5_r   <= idx5_nxt;
      idx6_r   <= idx6_nxt;
      num_r    <= num_nxt;
      seen_r   <= seen_nxt;
    end
  end

  assign res_valid      = accept && emit;
  assign res.char_byte  = cvalid ? data_byte : '0;
  assign res.char_valid = cvalid;
  assign res.field_mask = mask;
  assign res.string_end = send;
  assign res.table_done = done;

endmodule

`default_nettype wire

@@ hdl/smbx_out_buf.sv @@
// ----------------------------------------------------------------------------
// SMBIOS string extractor output buffer
// Two-entry result register that keeps input flowing while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module smbx_out_buf
  import smbx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic [1:0] count_r, count_nxt;
  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign space     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    unique case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) head_nxt = push_data;
        else tail_nxt = push_data;
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        head_nxt  = tail_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/smbios_string_field_extractor_top.sv @@
// ----------------------------------------------------------------------------
// SMBIOS string field extractor
// Streams the vendor, maker, product, version and board maker strings of an
// SMBIOS structure table.
//
// The table enters one byte per request on in_chan, with table_end on its
// last byte. Every accepted byte updates the record parser; a byte of a
// selected string, the end of a selected string or the stop of parsing
// yields one request on out_chan, which is registered in the output buffer
// before it appears. Other bytes yield nothing.
// Throughput is one byte per cycle while in_chan.ready is high: the parser
// state is updated in the cycle of acceptance. A two-entry output buffer
// lets one more byte be accepted while a result waits; in_chan.ready falls
// only when both entries are held. Synchronous reset clears the parser to
// the record header phase and empties the output buffer. After a request
// with table_end the parser starts afresh for the next table.
// ----------------------------------------------------------------------------
`default_nettype none

module smbios_string_field_extractor_top
  import smbx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  smbx_in_if.sink    in_chan,
  smbx_out_if.source out_chan
);

  logic    in_acc;
  logic    res_valid;
  result_t res;
  logic    space;
  result_t out_data;

  assign in_chan.ready = space;
  assign in_acc        = in_chan.valid && space;

  smbx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .data_byte (in_chan.data_byte),
    .table_end (in_chan.table_end),
    .res_valid (res_valid),
    .res       (res)
  );

  smbx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.char_byte  = out_data.char_byte;
  assign out_chan.char_valid = out_data.char_valid;
  assign out_chan.field_mask = out_data.field_mask;
  assign out_chan.string_end = out_data.string_end;
  assign out_chan.table_done = out_data.table_done;

`ifndef SYNTHESIS
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !space |-> out_chan.valid)
    else $error("output buffer full but shows no valid request");

  a_char_has_field: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.char_valid |-> res.field_mask != '0)
    else $error("character emitted without a field");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.field_mask != '0) || res.table_done)
    else $error("result emitted with neither field nor table stop");

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_acc)
    else $error("result produced without an accepted byte");
`endif

endmodule

`default_nettype wire
